@@ hw/rtl/convex_quad_overlap_test_core_assert.svh @@
// assertion macros shared by the convex quad overlap test rtl
`ifndef CONVEX_QUAD_OVERLAP_TEST_CORE_ASSERT_SVH
`define CONVEX_QUAD_OVERLAP_TEST_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CQOT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cqot assertion failed");

// next-cycle implication
`define CQOT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cqot assertion failed");

`else

`define CQOT_ASSERT_IMP(label, clk, rst, ante, cons)
`define CQOT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/cqot_pkg.sv @@
// types, widths and helpers of the convex quad overlap test
package cqot_pkg;

   localparam int COORD_BITS = 16;
   // coordinate width actually used, clamped to the 16-bit half
   localparam int CW = (COORD_BITS > 16) ? 16 : ((COORD_BITS < 2) ? 2 : COORD_BITS);
   localparam int DW = CW + 1;        // difference of two coordinates
   localparam int PW = 2 * DW;        // one product
   localparam int OW = PW + 1;        // difference of two products
   localparam int THICK_W = 10;
   localparam int Y_W = 16;
   localparam int Y_SUM_W = Y_W + 2;
   localparam logic [THICK_W-1:0] ROAD_THICKNESS_RESET = THICK_W'(13);

   typedef struct packed {
      logic [31:0]          a_corner_0;
      logic [31:0]          a_corner_1;
      logic [31:0]          a_corner_2;
      logic [31:0]          a_corner_3;
      logic [31:0]          b_corner_0;
      logic [31:0]          b_corner_1;
      logic [31:0]          b_corner_2;
      logic [31:0]          b_corner_3;
      logic signed [Y_W-1:0] a_low_y;
      logic signed [Y_W-1:0] a_high_y;
      logic signed [Y_W-1:0] b_low_y;
      logic signed [Y_W-1:0] b_high_y;
   } req_payload_type;

   typedef struct packed {
      logic overlap;
      logic vertically_apart;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] z;
   } pt_type;

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

   // stage load enables, one per register stage
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic load_out;
   } pipe_ctl_type;

   function automatic pt_type unpack_corner(input logic [31:0] word);
      pt_type p;
      p.x = signed'(word[16 +: CW]);
      p.z = signed'(word[0 +: CW]);
      return p;
   endfunction

   function automatic vec_type sub_pt(input pt_type p1, input pt_type p0);
      vec_type v;
      v.x = DW'(p1.x) - DW'(p0.x);
      v.z = DW'(p1.z) - DW'(p0.z);
      return v;
   endfunction

endpackage

@@ hw/rtl/cqot_diff.sv @@
// first stage: corner unpacking, edge and relative vectors, height test
module cqot_diff import cqot_pkg::*; (
   input  logic                  clock,
   input  pipe_ctl_type          ctl,
   input  req_payload_type       req,
   input  logic [THICK_W-1:0]    thickness,
   output vec_type [3:0]         a_edge,
   output vec_type [3:0]         b_edge,
   output vec_type [3:0][3:0]    a_rel,
   output vec_type [3:0][3:0]    b_rel,
   output logic                  apart
);

   pt_type [3:0]         a_pt;
   pt_type [3:0]         b_pt;
   vec_type [3:0]        a_edge_in, a_edge_ff;
   vec_type [3:0]        b_edge_in, b_edge_ff;
   vec_type [3:0][3:0]   a_rel_in, a_rel_ff;
   vec_type [3:0][3:0]   b_rel_in, b_rel_ff;
   logic                 apart_in, apart_ff;
   logic signed [Y_SUM_W-1:0] t_ext, a_top, b_top;

   always_comb begin
      a_pt[0] = unpack_corner(req.a_corner_0);
      a_pt[1] = unpack_corner(req.a_corner_1);
      a_pt[2] = unpack_corner(req.a_corner_2);
      a_pt[3] = unpack_corner(req.a_corner_3);
      b_pt[0] = unpack_corner(req.b_corner_0);
      b_pt[1] = unpack_corner(req.b_corner_1);
      b_pt[2] = unpack_corner(req.b_corner_2);
      b_pt[3] = unpack_corner(req.b_corner_3);
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a_edge_in[i] = sub_pt(a_pt[2'(i + 1)], a_pt[i]);
         b_edge_in[i] = sub_pt(b_pt[2'(i + 1)], b_pt[i]);
         for (int k = 0; k < 4; k++) begin
            // a_rel: corner k of b seen from corner i of a, and the other way round
            a_rel_in[i][k] = sub_pt(b_pt[k], a_pt[i]);
            b_rel_in[i][k] = sub_pt(a_pt[k], b_pt[i]);
         end
      end
   end

   assign t_ext    = Y_SUM_W'(signed'({1'b0, thickness}));
   assign a_top    = Y_SUM_W'(req.a_high_y) + t_ext;
   assign b_top    = Y_SUM_W'(req.b_high_y) + t_ext;
   assign apart_in = (a_top < Y_SUM_W'(req.b_low_y)) || (b_top < Y_SUM_W'(req.a_low_y));

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         a_edge_ff <= a_edge_in;
         b_edge_ff <= b_edge_in;
         a_rel_ff  <= a_rel_in;
         b_rel_ff  <= b_rel_in;
         apart_ff  <= apart_in;
      end
   end

   assign a_edge = a_edge_ff;
   assign b_edge = b_edge_ff;
   assign a_rel  = a_rel_ff;
   assign b_rel  = b_rel_ff;
   assign apart  = apart_ff;

endmodule

@@ hw/rtl/cqot_orient_lane.sv @@
// one orientation lane: two products, then the sign of their difference
module cqot_orient_lane import cqot_pkg::*; (
   input  logic          clock,
   input  pipe_ctl_type  ctl,
   input  vec_type       edge_vec,
   input  vec_type       rel_vec,
   output sign_type      side
);

   logic signed [PW-1:0] prod_xz_in, prod_xz_ff;
   logic signed [PW-1:0] prod_zx_in, prod_zx_ff;
   logic signed [OW-1:0] cross_v;
   sign_type             side_in, side_ff;

   assign prod_xz_in = PW'(edge_vec.x) * PW'(rel_vec.z);
   assign prod_zx_in = PW'(edge_vec.z) * PW'(rel_vec.x);

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         prod_xz_ff <= prod_xz_in;
         prod_zx_ff <= prod_zx_in;
      end
   end

   // exact cross product, strict sign only
   assign cross_v     = OW'(prod_xz_ff) - OW'(prod_zx_ff);
   assign side_in.neg = cross_v[OW-1];
   assign side_in.pos = !cross_v[OW-1] && (cross_v != '0);

   always_ff @(posedge clock) begin
      if (ctl.load_s3) begin
         side_ff <= side_in;
      end
   end

   assign side = side_ff;

endmodule

@@ hw/rtl/cqot_decide.sv @@
// last stage: edge crossings, containment and the result register
module cqot_decide import cqot_pkg::*; (
   input  logic                  clock,
   input  pipe_ctl_type          ctl,
   input  sign_type [3:0][3:0]   sa,
   input  sign_type [3:0][3:0]   sb,
   input  logic                  apart,
   output rsp_payload_type       rsp
);

   logic            footprint;
   rsp_payload_type rsp_in, rsp_ff;

   // sa[i][k]: side of corner k of b against edge i of a; sb the mirror
   always_comb begin
      logic     hit;
      logic     s_pos, s_neg;
      sign_type s0, s1, t0, t1;
      hit = 1'b0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s0 = sa[i][j];
            s1 = sa[i][2'(j + 1)];
            t0 = sb[j][i];
            t1 = sb[j][2'(i + 1)];
            if (((s0.pos && s1.neg) || (s0.neg && s1.pos)) &&
                ((t0.pos && t1.neg) || (t0.neg && t1.pos))) begin
               hit = 1'b1;
            end
         end
      end
      for (int k = 0; k < 4; k++) begin
         // corner k of b inside a
         s_pos = 1'b0;
         s_neg = 1'b0;
         for (int i = 0; i < 4; i++) begin
            s_pos = s_pos | sa[i][k].pos;
            s_neg = s_neg | sa[i][k].neg;
         end
         if (s_pos != s_neg) begin
            hit = 1'b1;
         end
         // corner k of a inside b
         s_pos = 1'b0;
         s_neg = 1'b0;
         for (int j = 0; j < 4; j++) begin
            s_pos = s_pos | sb[j][k].pos;
            s_neg = s_neg | sb[j][k].neg;
         end
         if (s_pos != s_neg) begin
            hit = 1'b1;
         end
      end
      footprint = hit;
   end

   assign rsp_in.overlap          = footprint && !apart;
   assign rsp_in.vertically_apart = apart;

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ hw/rtl/convex_quad_overlap_test_core.sv @@
// top level of the convex quad overlap test
// Tests two convex quads, each four (x,z) corners plus a low and high height, for
// footprint overlap and vertical separation, and gives one result per item. The
// block takes one item per clock cycle sustained while the output is not stalled.
// A result passes four register stages, the first of which loads at the input
// transfer: edge and corner differences, 64 parallel 17x17 multipliers, subtract
// and sign, and the decision register. Downstream stall holds the pipeline in
// place, and empty stages still take new items. road_thickness resets to 13 and
// must be written through the csr port only while no item is in flight; the block
// itself does not enforce this.
`include "convex_quad_overlap_test_core_assert.svh"

module convex_quad_overlap_test_core import cqot_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [THICK_W-1:0]  csr_data
);

   logic [THICK_W-1:0] road_thickness_ff;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic               apart_s2_ff, apart_s3_ff;
   logic               s1_ready, s2_ready, s3_ready, out_ready;
   pipe_ctl_type       ctl;

   vec_type [3:0]        a_edge, b_edge;
   vec_type [3:0][3:0]   a_rel, b_rel;
   logic                 apart_s1;
   sign_type [3:0][3:0]  sa, sb;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         road_thickness_ff <= ROAD_THICKNESS_RESET;
      end else if (csr_valid && csr_ready) begin
         road_thickness_ff <= csr_data;
      end
   end

   // a stage moves when the one after it is empty or moving
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign ctl.load_s1  = s1_ready;
   assign ctl.load_s2  = s2_ready;
   assign ctl.load_s3  = s3_ready;
   assign ctl.load_out = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // height test result rides along with the sign stages
   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         apart_s2_ff <= apart_s1;
      end
      if (ctl.load_s3) begin
         apart_s3_ff <= apart_s2_ff;
      end
   end

   cqot_diff u_diff (
      .clock     (clock),
      .ctl       (ctl),
      .req       (req_payload),
      .thickness (road_thickness_ff),
      .a_edge    (a_edge),
      .b_edge    (b_edge),
      .a_rel     (a_rel),
      .b_rel     (b_rel),
      .apart     (apart_s1)
   );

   for (genvar i = 0; i < 4; i++) begin : g_edge
      for (genvar k = 0; k < 4; k++) begin : g_corner
         cqot_orient_lane u_lane_a (
            .clock    (clock),
            .ctl      (ctl),
            .edge_vec (a_edge[i]),
            .rel_vec  (a_rel[i][k]),
            .side     (sa[i][k])
         );
         cqot_orient_lane u_lane_b (
            .clock    (clock),
            .ctl      (ctl),
            .edge_vec (b_edge[i]),
            .rel_vec  (b_rel[i][k]),
            .side     (sb[i][k])
         );
      end
   end

   cqot_decide u_decide (
      .clock (clock),
      .ctl   (ctl),
      .sa    (sa),
      .sb    (sb),
      .apart (apart_s3_ff),
      .rsp   (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

   `CQOT_ASSERT_IMP(a_no_overlap_when_apart, clock, reset, rsp_valid_ff, !(rsp_payload.overlap && rsp_payload.vertically_apart))
   `CQOT_ASSERT_IMP(a_flow_when_unstalled, clock, reset, !rsp_stall, !req_stall)
   `CQOT_ASSERT_NXT(a_s1_held_on_stall, clock, reset, s1_valid_ff && !s2_ready, s1_valid_ff)
   `CQOT_ASSERT_NXT(a_s3_held_on_stall, clock, reset, s3_valid_ff && !out_ready, s3_valid_ff && rsp_valid_ff)

endmodule
